// ----- rtl/gss_pkg.sv -----
// Shared types, constants and helpers for the golden-section search engine.
package gss_pkg;

   // Request modes and result kinds
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_VALUE = 1'b1;
   localparam logic KIND_EVAL  = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // Register indexes on the CSR port
   localparam logic CSR_MAX_ITERATIONS = 1'b0;
   localparam logic CSR_TOLERANCE      = 1'b1;

   // Register reset values
   localparam logic [15:0] MAX_ITERATIONS_RESET = 16'd500;
   localparam logic [31:0] TOLERANCE_RESET      = 32'd42950;

   // 1 - golden ratio conjugate as a Q0.32 fraction, and the rounding half
   localparam logic [31:0] GOLDEN_C_Q32 = 32'd1640531521;
   localparam logic [63:0] ROUND_HALF   = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] left_end;
      logic signed [31:0] middle;
      logic signed [31:0] right_end;
      logic signed [31:0] func_value;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] eval_point;
      logic signed [31:0] best_point;
      logic signed [31:0] best_value;
      logic        [15:0] evaluations_used;
   } rsp_type;

   // magnitude of a signed 32-bit value, exact as unsigned
   function automatic logic [31:0] abs32(input logic signed [31:0] x);
      abs32 = x[31] ? (~x + 32'd1) : x;
   endfunction

   // |hi - lo| for two signed 32-bit values; always fits 32 bits unsigned
   function automatic logic [31:0] abs_diff(input logic signed [31:0] hi,
                                            input logic signed [31:0] lo);
      logic signed [32:0] d;
      logic signed [32:0] nd;
      d  = {hi[31], hi} - {lo[31], lo};
      nd = -d;
      abs_diff = d[32] ? nd[31:0] : d[31:0];
   endfunction

endpackage

// ----- rtl/gss_golden.sv -----
// Golden point unit: base + C * (toward - base), rounded and saturated.
module gss_golden import gss_pkg::*; (
   input  logic signed [31:0] base,
   input  logic signed [31:0] toward,
   output logic signed [31:0] point
);

   logic signed [32:0] diff;
   logic        [31:0] mag;
   logic        [63:0] prod;
   logic        [31:0] step;
   logic signed [33:0] base_wide;
   logic signed [33:0] step_wide;
   logic signed [33:0] sum;

   assign diff      = {toward[31], toward} - {base[31], base};
   assign mag       = abs_diff(toward, base);
   // round half away from zero on the magnitude
   assign prod      = ({32'd0, mag} * {32'd0, GOLDEN_C_Q32}) + ROUND_HALF;
   assign step      = prod[63:32];
   assign base_wide = {{2{base[31]}}, base};
   assign step_wide = {2'b00, step};
   assign sum       = diff[32] ? (base_wide - step_wide) : (base_wide + step_wide);

   always_comb begin
      if (!sum[33] && (sum[32:31] != 2'b00)) begin
         point = 32'sh7FFF_FFFF;
      end else if (sum[33] && (sum[32:31] != 2'b11)) begin
         point = 32'sh8000_0000;
      end else begin
         point = sum[31:0];
      end
   end

endmodule

// ----- rtl/gss_stop.sv -----
// Stopping test: evaluation limit and relative bracket width against tolerance.
module gss_stop import gss_pkg::*; (
   input  logic signed [31:0] outer_low,
   input  logic signed [31:0] outer_high,
   input  logic signed [31:0] inner_low,
   input  logic signed [31:0] inner_high,
   input  logic        [15:0] eval_count,
   input  logic        [15:0] max_iterations,
   input  logic        [31:0] tolerance,
   output logic               keep_going
);

   logic [31:0] width;
   logic [32:0] mag_sum;
   logic [64:0] lhs;
   logic [64:0] rhs;

   assign width   = abs_diff(outer_high, outer_low);
   assign mag_sum = {1'b0, abs32(inner_low)} + {1'b0, abs32(inner_high)};
   assign lhs     = {1'b0, width, 32'd0};
   assign rhs     = {33'd0, tolerance} * {32'd0, mag_sum};

   assign keep_going = (eval_count < max_iterations) && (lhs > rhs);

endmodule

// ----- rtl/golden_section_search.sv -----
// Top level of the golden-section minimum search engine.
//
// Golden-section minimum search in signed Q16.16. A start request (mode 0)
// loads a bracket (left_end, middle, right_end); the engine answers with an
// evaluation result (kind 0) naming the point at which the function must be
// evaluated, and each value request (mode 1) brings that function value back.
// Every value narrows the bracket by the golden ratio until max_iterations
// evaluations are done or the outer bracket width is no more than
// tolerance * (|inner_low| + |inner_high|); the engine then returns a finished
// result (kind 1) with the better inner point and its value (inner_high on a
// tie). A limit of zero finishes at once at the middle point with value 0; a
// limit of one asks for the middle point only. A value request while idle is
// dropped with no result, and a start request while busy drops the running
// search. Every request gives at most one result: it waits in the input
// register, then passes through the state update (golden-point multiplier and
// tolerance multiplier in parallel) into the result register. A new request
// is taken every cycle as long as results are taken; a stalled result holds
// the input register, which then backs up req_ready.
// Write max_iterations and tolerance only while no search is running.
module golden_section_search import gss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // configuration write port
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   // search phase codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_FIRST  = 3'd1;
   localparam logic [2:0] PH_SECOND = 3'd2;
   localparam logic [2:0] PH_LOOP   = 3'd3;
   localparam logic [2:0] PH_SINGLE = 3'd4;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // configuration
   logic [15:0] max_iterations_ff, max_iterations_in;
   logic [31:0] tolerance_ff, tolerance_in;

   // search state
   logic signed [31:0] outer_low_ff, outer_low_in;
   logic signed [31:0] inner_low_ff, inner_low_in;
   logic signed [31:0] inner_high_ff, inner_high_in;
   logic signed [31:0] outer_high_ff, outer_high_in;
   logic signed [31:0] value_low_ff, value_low_in;
   logic signed [31:0] value_high_ff, value_high_in;
   logic signed [31:0] start_middle_ff, start_middle_in;
   logic        [15:0] eval_count_ff, eval_count_in;
   logic        [2:0]  phase_ff, phase_in;
   logic               pending_side_ff, pending_side_in;

   // datapath
   logic               proc_fire;
   logic signed [31:0] value_arg;
   logic signed [31:0] value_low_upd;
   logic signed [31:0] value_high_upd;
   logic        [15:0] count_upd;
   logic               go_high;
   logic               start_wide;
   logic signed [31:0] golden_base;
   logic signed [31:0] golden_toward;
   logic signed [31:0] golden_point;
   logic               keep_going;

   // Process the held request once the result register is free or drains now.
   assign proc_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      max_iterations_in = max_iterations_ff;
      tolerance_in      = tolerance_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_ITERATIONS: max_iterations_in = csr_wdata[15:0];
            CSR_TOLERANCE:      tolerance_in      = csr_wdata;
            default:            tolerance_in      = tolerance_ff;
         endcase
      end
   end

   // Fold the incoming value into the inner-point values before the test.
   assign value_arg = in_data_ff.func_value;

   always_comb begin
      value_low_upd  = value_low_ff;
      value_high_upd = value_high_ff;
      count_upd      = eval_count_ff;
      case (phase_ff)
         PH_SINGLE: begin
            count_upd = 16'd1;
         end
         PH_FIRST: begin
            value_low_upd = value_arg;
            count_upd     = 16'd1;
         end
         PH_SECOND: begin
            value_high_upd = value_arg;
            count_upd      = 16'd2;
         end
         PH_LOOP: begin
            if (pending_side_ff) begin
               value_high_upd = value_arg;
            end else begin
               value_low_upd = value_arg;
            end
            if (eval_count_ff != 16'hFFFF) begin
               count_upd = eval_count_ff + 16'd1;
            end
         end
         default: begin
            count_upd = eval_count_ff;
         end
      endcase
   end

   // Move the bracket towards the higher side when its value is smaller.
   assign go_high    = value_high_upd < value_low_upd;
   assign start_wide = abs_diff(in_data_ff.right_end, in_data_ff.middle) >
                       abs_diff(in_data_ff.middle, in_data_ff.left_end);

   // One golden-point unit, shared between the start and the loop step.
   always_comb begin
      if (in_data_ff.mode == MODE_START) begin
         golden_base   = in_data_ff.middle;
         golden_toward = start_wide ? in_data_ff.right_end : in_data_ff.left_end;
      end else begin
         golden_base   = go_high ? inner_high_ff : inner_low_ff;
         golden_toward = go_high ? outer_high_ff : outer_low_ff;
      end
   end

   gss_golden u_golden (
      .base   (golden_base),
      .toward (golden_toward),
      .point  (golden_point)
   );

   gss_stop u_stop (
      .outer_low      (outer_low_ff),
      .outer_high     (outer_high_ff),
      .inner_low      (inner_low_ff),
      .inner_high     (inner_high_ff),
      .eval_count     (count_upd),
      .max_iterations (max_iterations_ff),
      .tolerance      (tolerance_ff),
      .keep_going     (keep_going)
   );

   // State update and result formation for the held request.
   always_comb begin
      outer_low_in    = outer_low_ff;
      inner_low_in    = inner_low_ff;
      inner_high_in   = inner_high_ff;
      outer_high_in   = outer_high_ff;
      value_low_in    = value_low_ff;
      value_high_in   = value_high_ff;
      start_middle_in = start_middle_ff;
      eval_count_in   = eval_count_ff;
      phase_in        = phase_ff;
      pending_side_in = pending_side_ff;
      rsp_data_in     = '0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (proc_fire) begin
         rsp_valid_in = 1'b0;
         if (in_data_ff.mode == MODE_START) begin
            eval_count_in   = 16'd0;
            pending_side_in = 1'b0;
            start_middle_in = in_data_ff.middle;
            rsp_valid_in    = 1'b1;
            if (max_iterations_ff == 16'd0) begin
               // finish at once at the middle point
               phase_in               = PH_IDLE;
               rsp_data_in.kind       = KIND_DONE;
               rsp_data_in.best_point = in_data_ff.middle;
            end else if (max_iterations_ff == 16'd1) begin
               phase_in               = PH_SINGLE;
               rsp_data_in.kind       = KIND_EVAL;
               rsp_data_in.eval_point = in_data_ff.middle;
            end else begin
               phase_in         = PH_FIRST;
               outer_low_in     = in_data_ff.left_end;
               outer_high_in    = in_data_ff.right_end;
               rsp_data_in.kind = KIND_EVAL;
               if (start_wide) begin
                  inner_low_in           = in_data_ff.middle;
                  inner_high_in          = golden_point;
                  rsp_data_in.eval_point = in_data_ff.middle;
               end else begin
                  inner_high_in          = in_data_ff.middle;
                  inner_low_in           = golden_point;
                  rsp_data_in.eval_point = golden_point;
               end
            end
         end else begin
            value_low_in  = value_low_upd;
            value_high_in = value_high_upd;
            eval_count_in = count_upd;
            rsp_data_in.evaluations_used = count_upd;
            case (phase_ff)
               PH_SINGLE: begin
                  phase_in               = PH_IDLE;
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.kind       = KIND_DONE;
                  rsp_data_in.best_point = start_middle_ff;
                  rsp_data_in.best_value = value_arg;
               end
               PH_FIRST: begin
                  phase_in               = PH_SECOND;
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.kind       = KIND_EVAL;
                  rsp_data_in.eval_point = inner_high_ff;
               end
               PH_SECOND, PH_LOOP: begin
                  rsp_valid_in = 1'b1;
                  if (!keep_going) begin
                     phase_in         = PH_IDLE;
                     rsp_data_in.kind = KIND_DONE;
                     if (value_low_upd < value_high_upd) begin
                        rsp_data_in.best_point = inner_low_ff;
                        rsp_data_in.best_value = value_low_upd;
                     end else begin
                        rsp_data_in.best_point = inner_high_ff;
                        rsp_data_in.best_value = value_high_upd;
                     end
                  end else begin
                     phase_in         = PH_LOOP;
                     rsp_data_in.kind = KIND_EVAL;
                     if (go_high) begin
                        // advance the low side: the high inner point moves in
                        outer_low_in           = inner_low_ff;
                        inner_low_in           = inner_high_ff;
                        inner_high_in          = golden_point;
                        value_low_in           = value_high_upd;
                        pending_side_in        = 1'b1;
                        rsp_data_in.eval_point = golden_point;
                     end else begin
                        // pull the high side in
                        outer_high_in          = inner_high_ff;
                        inner_high_in          = inner_low_ff;
                        inner_low_in           = golden_point;
                        value_high_in          = value_low_upd;
                        pending_side_in        = 1'b0;
                        rsp_data_in.eval_point = golden_point;
                     end
                  end
               end
               default: begin
                  // value with no search running: drop it
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         max_iterations_ff <= MAX_ITERATIONS_RESET;
         tolerance_ff      <= TOLERANCE_RESET;
         outer_low_ff      <= '0;
         inner_low_ff      <= '0;
         inner_high_ff     <= '0;
         outer_high_ff     <= '0;
         value_low_ff      <= '0;
         value_high_ff     <= '0;
         start_middle_ff   <= '0;
         eval_count_ff     <= '0;
         phase_ff          <= PH_IDLE;
         pending_side_ff   <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         max_iterations_ff <= max_iterations_in;
         tolerance_ff      <= tolerance_in;
         outer_low_ff      <= outer_low_in;
         inner_low_ff      <= inner_low_in;
         inner_high_ff     <= inner_high_in;
         outer_high_ff     <= outer_high_in;
         value_low_ff      <= value_low_in;
         value_high_ff     <= value_high_in;
         start_middle_ff   <= start_middle_in;
         eval_count_ff     <= eval_count_in;
         phase_ff          <= phase_in;
         pending_side_ff   <= pending_side_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (proc_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A held request is never overwritten before it is processed.
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_data_ff))
      else $error("held request lost before processing");

   // A finished result always leaves the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      proc_fire && rsp_valid_in && (rsp_data_in.kind == KIND_DONE)
      |=> phase_ff == PH_IDLE)
      else $error("search still running after finished result");

   // An evaluation result always leaves a search waiting for its value.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      proc_fire && rsp_valid_in && (rsp_data_in.kind == KIND_EVAL)
      |=> phase_ff != PH_IDLE)
      else $error("evaluation asked with no search running");

   // A value while idle gives no result.
   a_idle_drop: assert property (@(posedge clock) disable iff (reset)
      proc_fire && (in_data_ff.mode == MODE_VALUE) && (phase_ff == PH_IDLE)
      |=> !rsp_valid_ff)
      else $error("result produced for a value while idle");

endmodule
